### rtl/bgm_pkg.sv
// Shared types, codes and reset constants for the button gesture menu controller.
package bgm_pkg;

    localparam int CFG_W         = 16;
    localparam int CLICK_W       = 4;
    localparam int SLOT_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int MENU_ENTRIES_DEF = 3;

    localparam logic [CFG_W-1:0]   CLICK_GAP_RST     = 16'd300;
    localparam logic [CFG_W-1:0]   LONG_PRESS_RST    = 16'd600;
    localparam logic [CFG_W-1:0]   VLONG_PRESS_RST   = 16'd2000;
    localparam logic [CFG_W-1:0]   SINCE_MAX         = 16'hFFFF;
    localparam logic [CLICK_W-1:0] CLICK_MAX         = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VLONG_PRESS = 2'd2;

    typedef enum logic [2:0] {
        GEST_NONE   = 3'd0,
        GEST_VLONG  = 3'd1,
        GEST_LONG   = 3'd2,
        GEST_SINGLE = 3'd3,
        GEST_DOUBLE = 3'd4,
        GEST_TRIPLE = 3'd5,
        GEST_MANY   = 3'd6
    } gesture_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_POWER_OFF = 3'd1,
        ACT_TARE      = 3'd2,
        ACT_CALIBRATE = 3'd3,
        ACT_WIFI_ON   = 3'd4
    } action_t;

    typedef struct packed {
        logic [CFG_W-1:0] click_gap;
        logic [CFG_W-1:0] long_press;
        logic [CFG_W-1:0] vlong_press;
    } cfg_t;

    typedef struct packed {
        gesture_t           gesture;
        action_t            action;
        logic [CLICK_W-1:0] click_total;
        logic               menu_shown;
        logic [SLOT_W-1:0]  menu_slot;
    } result_t;

endpackage

### rtl/bgm_cfg_regs.sv
// Configuration register file holding the three press timing thresholds.
module bgm_cfg_regs
    import bgm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLICK_GAP:   cfg_next.click_gap   = cfg_data;
                REG_LONG_PRESS:  cfg_next.long_press  = cfg_data;
                REG_VLONG_PRESS: cfg_next.vlong_press = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_gap   <= CLICK_GAP_RST;
            cfg_reg.long_press  <= LONG_PRESS_RST;
            cfg_reg.vlong_press <= VLONG_PRESS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/bgm_core.sv
// Gesture classifier and menu state: one level sample in, one result out per request.
module bgm_core
    import bgm_pkg::*;
#(
    parameter int MENU_ENTRIES = MENU_ENTRIES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    pressed,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int CUR_W = (MENU_ENTRIES > 1) ? $clog2(MENU_ENTRIES) : 1;
    localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(MENU_ENTRIES - 1);

    logic               level_reg,  level_next;
    logic [CFG_W-1:0]   since_reg,  since_next;
    logic [CLICK_W-1:0] clicks_reg, clicks_next;
    logic               menu_reg,   menu_next;
    logic [CUR_W-1:0]   cursor_reg, cursor_next;

    logic [CFG_W-1:0]   since_inc;
    logic               released;
    logic               evaluate;
    logic [SLOT_W-1:0]  cursor_wide;

    assign cursor_wide = SLOT_W'(cursor_reg);

    always_comb
    begin
        since_inc   = (since_reg != SINCE_MAX) ? since_reg + 1'b1 : since_reg;
        released    = (pressed != level_reg) && !pressed;
        level_next  = pressed;
        since_next  = (pressed != level_reg) ? '0 : since_inc;
        clicks_next = clicks_reg;
        menu_next   = menu_reg;
        cursor_next = cursor_reg;
        result.gesture     = GEST_NONE;
        result.action      = ACT_NONE;
        result.click_total = '0;

        // The held time of the press that just ended is the count before clearing.
        if (released)
        begin
            if (since_inc > cfg.vlong_press)
            begin
                result.gesture = GEST_VLONG;
                result.action  = ACT_POWER_OFF;
            end
            else if (since_inc > cfg.long_press)
            begin
                result.gesture = GEST_LONG;
            end
            else if (clicks_reg != CLICK_MAX)
            begin
                clicks_next = clicks_reg + 1'b1;
            end
        end

        // The idle count is zero on a release, so this never fires on the same tick.
        evaluate = !pressed && (clicks_next != '0) && (since_next > cfg.click_gap);
        if (evaluate)
        begin
            result.click_total = clicks_next;
            case (clicks_next)
                4'd1:
                begin
                    result.gesture = GEST_SINGLE;
                    if (menu_reg)
                        cursor_next = (cursor_reg == CUR_LAST) ? '0 : cursor_reg + 1'b1;
                end
                4'd2:
                begin
                    result.gesture = GEST_DOUBLE;
                    if (menu_reg)
                    begin
                        case (cursor_wide)
                            4'd0:    result.action = ACT_TARE;
                            4'd1:    result.action = ACT_CALIBRATE;
                            4'd2:    result.action = ACT_WIFI_ON;
                            default: result.action = ACT_NONE;
                        endcase
                        menu_next = 1'b0;
                    end
                end
                4'd3:
                begin
                    result.gesture = GEST_TRIPLE;
                    if (!menu_reg)
                    begin
                        menu_next   = 1'b1;
                        cursor_next = '0;
                    end
                end
                default: result.gesture = GEST_MANY;
            endcase
            clicks_next = '0;
        end

        result.menu_shown = menu_next;
        result.menu_slot  = SLOT_W'(cursor_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= 1'b0;
            since_reg  <= '0;
            clicks_reg <= '0;
            menu_reg   <= 1'b0;
            cursor_reg <= '0;
        end
        else if (step)
        begin
            level_reg  <= level_next;
            since_reg  <= since_next;
            clicks_reg <= clicks_next;
            menu_reg   <= menu_next;
            cursor_reg <= cursor_next;
        end
    end

endmodule

### rtl/bgm_out_reg.sv
// Result register that decouples the output handshake from the input side.
module bgm_out_reg
    import bgm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    can_load,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

### rtl/button_gesture_menu_controller.sv
// Top level of the button gesture menu controller.
//
// Each request carries one button level sample (one per millisecond tick) and
// produces exactly one result: the gesture recognized on that tick, the menu
// action it triggers, the click count of a click gesture, and the menu state
// after the tick. A request is taken every cycle while the output register is
// empty or read in that cycle; its result appears in the output register on
// the next cycle. Timing thresholds are written through the configuration
// port while idle; the user must keep to this, the block does not enforce it.
module button_gesture_menu_controller
    import bgm_pkg::*;
#(
    parameter int MENU_ENTRIES = MENU_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 pressed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           gesture,
    output logic [2:0]           action,
    output logic [CLICK_W-1:0]   click_total,
    output logic                 menu_shown,
    output logic [SLOT_W-1:0]    menu_slot,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t held_result;
    logic    step;

    assign cfg_ready = 1'b1;
    assign step      = in_valid && in_ready;

    bgm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgm_core #(
        .MENU_ENTRIES (MENU_ENTRIES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pressed (pressed),
        .cfg     (cfg),
        .result  (core_result)
    );

    bgm_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (core_result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .can_load   (in_ready),
        .result_out (held_result)
    );

    assign gesture     = held_result.gesture;
    assign action      = held_result.action;
    assign click_total = held_result.click_total;
    assign menu_shown  = held_result.menu_shown;
    assign menu_slot   = held_result.menu_slot;

endmodule

### rtl/bgm_checker.sv
// Port-level checker for the button gesture menu controller, with its bind.
module bgm_checker
    import bgm_pkg::*;
#(
    parameter int MENU_ENTRIES = MENU_ENTRIES_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 pressed,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [2:0]           gesture,
    input logic [2:0]           action,
    input logic [CLICK_W-1:0]   click_total,
    input logic                 menu_shown,
    input logic [SLOT_W-1:0]    menu_slot,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    // A result that is not taken holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gesture) && $stable(action)
            && $stable(menu_slot))
        else $error("result changed while stalled");

    // A very long press is always reported with power off.
    a_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (gesture == GEST_VLONG) |-> action == ACT_POWER_OFF)
        else $error("very long press without power off");

    // The click count matches the reported click gesture.
    a_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((gesture == GEST_SINGLE) == (click_total == 4'd1))
            && ((gesture == GEST_DOUBLE) == (click_total == 4'd2))
            && ((gesture == GEST_TRIPLE) == (click_total == 4'd3)))
        else $error("click total disagrees with gesture");

    // A menu confirmation comes from a double click and closes the menu.
    a_confirm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_TARE || action == ACT_CALIBRATE
            || action == ACT_WIFI_ON) |-> (gesture == GEST_DOUBLE) && !menu_shown)
        else $error("menu action without closing double click");

    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(menu_slot) < MENU_ENTRIES)
        else $error("menu slot out of range");

endmodule

bind button_gesture_menu_controller bgm_checker #(.MENU_ENTRIES(MENU_ENTRIES)) u_bgm_checker (.*);
